// ----- src/urtb_pkg.sv -----
// Shared types and codes for the UART receive/transmit ring buffers.
package urtb_pkg;

    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;
    localparam int LVL_W  = 7;
    localparam int ERR_W  = 2;

    localparam logic [OP_W-1:0] OP_RX_BYTE    = 3'd0;
    localparam logic [OP_W-1:0] OP_HOST_READ  = 3'd1;
    localparam logic [OP_W-1:0] OP_HOST_WRITE = 3'd2;
    localparam logic [OP_W-1:0] OP_TX_READY   = 3'd3;
    localparam logic [OP_W-1:0] OP_STATUS     = 3'd4;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RX_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TX_FULL  = 2'd2;

    typedef struct packed {
        logic push;
        logic pop;
    } ring_cmd_t;

    typedef struct packed {
        logic             read_hit;
        logic             send_hit;
        logic             overrun;
        logic [ERR_W-1:0] err;
    } stage_t;

endpackage

// ----- src/urtb_if.sv -----
// Valid/ready channel interfaces for request and response beats.
interface urtb_req_if
    import urtb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface urtb_rsp_if
    import urtb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_byte;
    logic              send_valid;
    logic [BYTE_W-1:0] send_byte;
    logic [LVL_W-1:0]  rx_level;
    logic [LVL_W-1:0]  tx_level;
    logic              sender_active;
    logic              overrun;
    logic [ERR_W-1:0]  error_code;

    modport source (output valid, output read_byte, output send_valid, output send_byte,
                    output rx_level, output tx_level, output sender_active,
                    output overrun, output error_code, input ready);
    modport sink   (input valid, input read_byte, input send_valid, input send_byte,
                    input rx_level, input tx_level, input sender_active,
                    input overrun, input error_code, output ready);
endinterface

// ----- src/urtb_ring.sv -----
// Byte ring buffer: one synchronous memory, head pointer and fill count.
module urtb_ring
    import urtb_pkg::*;
#(
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ring_cmd_t         cmd,
    input  logic [BYTE_W-1:0] wdata,
    output logic [CW-1:0]     count,
    output logic [BYTE_W-1:0] rdata
);

    localparam int SW = AW + 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [BYTE_W-1:0] rdata_reg;
    logic [SW-1:0]     slot_sum;
    logic [AW-1:0]     slot;
    logic              full;
    logic [AW-1:0]     head_inc;

    assign full     = (count_reg == FULL_CNT);
    assign slot_sum = SW'(head_reg) + SW'(count_reg);
    assign slot     = (slot_sum >= DEPTH_S) ? AW'(slot_sum - DEPTH_S) : AW'(slot_sum);
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.push)
        begin
            if (full)
            begin
                head_next = head_inc;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else if (cmd.pop)
        begin
            head_next  = head_inc;
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[slot] <= wdata;
        end
        if (cmd.pop)
        begin
            rdata_reg <= mem[head_reg];
        end
    end

    assign count = count_reg;
    assign rdata = rdata_reg;

    // pop is only issued on a non-empty ring
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> count_reg != '0)
        else $error("ring pop while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("ring count above depth");

    a_overwrite_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push && full |=> count_reg == FULL_CNT)
        else $error("overwrite changed a full count");

endmodule

// ----- src/uart_rx_tx_ring_buffers.sv -----
// Top level: UART receive and transmit ring buffers with one result per request.
//
// Usage:
//   req (sink): operation and data_byte. Operations: byte received, host read,
//   host write, transmitter ready, status (codes five to seven act as status).
//   rsp (source): one beat per request beat with the popped bytes, ring levels
//   after the request, sender_active, overrun and error_code.
// Timing:
//   A request is accepted when req.valid and req.ready are both high; the ring
//   memory is read and stage s1 is loaded at the accepting edge, and the output
//   register is loaded with the response beat when s1 advances.
//   Throughput is one request per cycle while rsp.ready stays high, set by the
//   single-port access of each ring memory per request.
// Reset:
//   rst_n clears both heads, both fill counts, the sender-active mark and the
//   pipeline valids. Ring contents are not cleared; only written entries are ever read.
// Stalls:
//   When rsp.ready is low the output register holds its beat, one more request
//   may sit in the memory-read stage, and req.ready then drops until the
//   response beat is taken.
module uart_rx_tx_ring_buffers
    import urtb_pkg::*;
#(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input logic         clk,
    input logic         rst_n,
    urtb_req_if.sink    req,
    urtb_rsp_if.source  rsp
);

    localparam int RCW = $clog2(RX_DEPTH + 1);
    localparam int TCW = $clog2(TX_DEPTH + 1);
    localparam logic [RCW-1:0] RX_FULL = RCW'(RX_DEPTH);
    localparam logic [TCW-1:0] TX_FULL = TCW'(TX_DEPTH);

    ring_cmd_t         rx_cmd, tx_cmd;
    logic [RCW-1:0]    rx_count;
    logic [TCW-1:0]    tx_count;
    logic [BYTE_W-1:0] rx_rdata, tx_rdata;

    logic   accept, s1_adv;
    logic   s1_valid_reg;
    stage_t s1_reg, s1_next;
    logic   sending_reg, sending_next;
    logic   rx_full, rx_empty, tx_full, tx_empty;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] read_byte_reg;
    logic              send_valid_reg;
    logic [BYTE_W-1:0] send_byte_reg;
    logic [LVL_W-1:0]  rx_level_reg;
    logic [LVL_W-1:0]  tx_level_reg;
    logic              active_reg;
    logic              overrun_reg;
    logic [ERR_W-1:0]  err_reg;

    urtb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (rx_cmd),
        .wdata (req.data_byte),
        .count (rx_count),
        .rdata (rx_rdata)
    );

    urtb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tx_cmd),
        .wdata (req.data_byte),
        .count (tx_count),
        .rdata (tx_rdata)
    );

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign accept    = req.valid && req.ready;

    assign rx_full  = (rx_count == RX_FULL);
    assign rx_empty = (rx_count == '0);
    assign tx_full  = (tx_count == TX_FULL);
    assign tx_empty = (tx_count == '0);

    always_comb
    begin
        rx_cmd       = '0;
        tx_cmd       = '0;
        s1_next      = '0;
        s1_next.err  = ERR_NONE;
        sending_next = sending_reg;
        case (req.operation)
            OP_RX_BYTE:
            begin
                rx_cmd.push     = accept;
                s1_next.overrun = rx_full;
            end
            OP_HOST_READ:
            begin
                if (rx_empty)
                begin
                    s1_next.err = ERR_RX_EMPTY;
                end
                else
                begin
                    rx_cmd.pop       = accept;
                    s1_next.read_hit = 1'b1;
                end
            end
            OP_HOST_WRITE:
            begin
                if (tx_full)
                begin
                    s1_next.err = ERR_TX_FULL;
                end
                else
                begin
                    tx_cmd.push = accept;
                    if (accept)
                    begin
                        sending_next = 1'b1;
                    end
                end
            end
            OP_TX_READY:
            begin
                if (tx_empty)
                begin
                    if (accept)
                    begin
                        sending_next = 1'b0;
                    end
                end
                else
                begin
                    tx_cmd.pop       = accept;
                    s1_next.send_hit = 1'b1;
                end
            end
            default:
            begin
                s1_next.err = ERR_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            sending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sending_reg <= sending_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // counts and sender mark reflect exactly the items up to the one in s1
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_adv)
        begin
            read_byte_reg  <= s1_reg.read_hit ? rx_rdata : '0;
            send_valid_reg <= s1_reg.send_hit;
            send_byte_reg  <= s1_reg.send_hit ? tx_rdata : '0;
            rx_level_reg   <= LVL_W'(rx_count);
            tx_level_reg   <= LVL_W'(tx_count);
            active_reg     <= sending_reg;
            overrun_reg    <= s1_reg.overrun;
            err_reg        <= s1_reg.err;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.read_byte     = read_byte_reg;
    assign rsp.send_valid    = send_valid_reg;
    assign rsp.send_byte     = send_byte_reg;
    assign rsp.rx_level      = rx_level_reg;
    assign rsp.tx_level      = tx_level_reg;
    assign rsp.sender_active = active_reg;
    assign rsp.overrun       = overrun_reg;
    assign rsp.error_code    = err_reg;

    a_write_sets_active: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.operation == OP_HOST_WRITE && !tx_full |=> sending_reg)
        else $error("host write did not mark sender active");

    a_ready_empty_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.operation == OP_TX_READY && tx_empty |=> !sending_reg)
        else $error("tx ready on empty ring left sender active");

    a_s1_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg)
        else $error("stalled stage item dropped");

    a_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && err_reg != ERR_NONE |-> !send_valid_reg && !overrun_reg)
        else $error("error beat carries a transfer");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the UART receive/transmit ring buffers.
module tb_top
    import urtb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH  = 64;
    localparam int HOLD_CYCLES = 60;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 10;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [BYTE_W-1:0] data_byte;
    } req_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              send_valid;
        logic [BYTE_W-1:0] send_byte;
        logic [LVL_W-1:0]  rx_level;
        logic [LVL_W-1:0]  tx_level;
        logic              sender_active;
        logic              overrun;
        logic [ERR_W-1:0]  error_code;
    } rsp_beat_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    urtb_req_if req ();
    urtb_rsp_if rsp ();

    uart_rx_tx_ring_buffers #(
        .RX_DEPTH (RING_DEPTH),
        .TX_DEPTH (RING_DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ring shadow state
    logic [BYTE_W-1:0] rx_mem [RING_DEPTH];
    logic [BYTE_W-1:0] tx_mem [RING_DEPTH];
    int                rx_first;
    int                tx_first;
    logic [LVL_W-1:0]  rx_fill;
    logic [LVL_W-1:0]  tx_fill;
    logic              tx_on;

    req_beat_t req_backlog [$];
    rsp_beat_t rsp_due [$];

    int req_idle_pct = 0;
    int rsp_idle_pct = 0;
    int hold_seq     = 0;
    int mismatches   = 0;
    int n_requests   = 0;
    int n_overruns   = 0;
    int n_empty_rd   = 0;
    int n_full_wr    = 0;
    int n_sent       = 0;
    int stall_cycles = 0;

    function automatic rsp_beat_t ring_step(logic [OP_W-1:0] op, logic [BYTE_W-1:0] d);
        rsp_beat_t r;
        int        slot;
        r = '0;
        case (op)
            OP_RX_BYTE:
            begin
                slot = (rx_first + rx_fill) % RING_DEPTH;
                rx_mem[slot] = d;
                if (rx_fill >= RING_DEPTH)
                begin
                    rx_first = (rx_first + 1) % RING_DEPTH;
                    r.overrun = 1'b1;
                end
                else
                begin
                    rx_fill = rx_fill + 1'b1;
                end
            end
            OP_HOST_READ:
            begin
                if (rx_fill == 0)
                begin
                    r.error_code = ERR_RX_EMPTY;
                end
                else
                begin
                    r.read_byte = rx_mem[rx_first];
                    rx_first = (rx_first + 1) % RING_DEPTH;
                    rx_fill = rx_fill - 1'b1;
                end
            end
            OP_HOST_WRITE:
            begin
                if (tx_fill >= RING_DEPTH)
                begin
                    r.error_code = ERR_TX_FULL;
                end
                else
                begin
                    slot = (tx_first + tx_fill) % RING_DEPTH;
                    tx_mem[slot] = d;
                    tx_fill = tx_fill + 1'b1;
                    tx_on = 1'b1;
                end
            end
            OP_TX_READY:
            begin
                if (tx_fill != 0)
                begin
                    r.send_valid = 1'b1;
                    r.send_byte = tx_mem[tx_first];
                    tx_first = (tx_first + 1) % RING_DEPTH;
                    tx_fill = tx_fill - 1'b1;
                end
                else
                begin
                    tx_on = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        r.rx_level      = rx_fill;
        r.tx_level      = tx_fill;
        r.sender_active = tx_on;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned exp, int unsigned act);
        if (exp != act)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp, act);
            mismatches++;
        end
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : drv
        req_beat_t nxt;
        rsp_beat_t exp;
        if (!rst_n)
        begin
            req.valid     <= 1'b0;
            req.operation <= OP_STATUS;
            req.data_byte <= '0;
            rx_first = 0;
            tx_first = 0;
            rx_fill  = '0;
            tx_fill  = '0;
            tx_on    = 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                exp = ring_step(req.operation, req.data_byte);
                rsp_due.push_back(exp);
                n_requests++;
                n_overruns += exp.overrun;
                n_empty_rd += (exp.error_code == ERR_RX_EMPTY);
                n_full_wr  += (exp.error_code == ERR_TX_FULL);
                n_sent     += exp.send_valid;
            end
            if (!req.valid || req.ready)
            begin
                if (req_backlog.size() > 0 && $urandom_range(99) >= req_idle_pct)
                begin
                    nxt = req_backlog.pop_front();
                    req.valid     <= 1'b1;
                    req.operation <= nxt.operation;
                    req.data_byte <= nxt.data_byte;
                end
                else
                begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin : mon
        int        hold_left;
        int        hold_seen;
        rsp_beat_t exp;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            hold_left = 0;
            hold_seen = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (rsp_due.size() == 0)
                begin
                    $error("response beat with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    exp = rsp_due.pop_front();
                    check_field("read_byte", exp.read_byte, rsp.read_byte);
                    check_field("send_valid", exp.send_valid, rsp.send_valid);
                    check_field("send_byte", exp.send_byte, rsp.send_byte);
                    check_field("rx_level", exp.rx_level, rsp.rx_level);
                    check_field("tx_level", exp.tx_level, rsp.tx_level);
                    check_field("sender_active", exp.sender_active, rsp.sender_active);
                    check_field("overrun", exp.overrun, rsp.overrun);
                    check_field("error_code", exp.error_code, rsp.error_code);
                end
            end
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= ($urandom_range(99) >= rsp_idle_pct);
            end
        end
    end

    // watchdog: no beat moving on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $error("no beat moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic add_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] d);
        req_beat_t b;
        b.operation = op;
        b.data_byte = d;
        req_backlog.push_back(b);
    endtask

    // weights in percent; the rest goes to status and the unused codes
    task automatic add_burst(int count, int w_rx, int w_rd, int w_wr, int w_tr);
        int               r;
        logic [OP_W-1:0]  op;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < w_rx)
                op = OP_RX_BYTE;
            else if (r < w_rx + w_rd)
                op = OP_HOST_READ;
            else if (r < w_rx + w_rd + w_wr)
                op = OP_HOST_WRITE;
            else if (r < w_rx + w_rd + w_wr + w_tr)
                op = OP_TX_READY;
            else
                op = OP_STATUS + OP_W'($urandom_range(3));
            add_item(op, BYTE_W'($urandom_range(255)));
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (req_backlog.size() != 0 || req.valid || rsp_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_profile(int s_idle, int r_idle, bit squeeze);
        req_idle_pct = s_idle;
        rsp_idle_pct = r_idle;
        add_burst(120, 80, 5, 5, 5);
        if (squeeze)
            hold_seq++;
        add_burst(120, 5, 5, 80, 5);
        add_burst(140, 2, 45, 2, 45);
        wait_drained();
    endtask

    initial
    begin
        req.valid     = 1'b0;
        req.operation = OP_STATUS;
        req.data_byte = '0;
        rsp.ready     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty rings, basic traffic, extremes and unused codes
        req_idle_pct = 8;
        rsp_idle_pct = 83;
        add_item(OP_STATUS, 8'h00);
        add_item(OP_HOST_READ, 8'hFF);
        add_item(OP_TX_READY, 8'hFF);
        add_item(OP_RX_BYTE, 8'h00);
        add_item(OP_RX_BYTE, 8'hFF);
        add_item(OP_RX_BYTE, 8'hA5);
        add_item(OP_HOST_READ, 8'h00);
        add_item(OP_HOST_READ, 8'h00);
        add_item(OP_STATUS, 8'hFF);
        add_item(OP_HOST_WRITE, 8'h00);
        add_item(OP_HOST_WRITE, 8'hFF);
        add_item(OP_TX_READY, 8'h00);
        add_item(OP_TX_READY, 8'h00);
        add_item(OP_TX_READY, 8'h00);
        add_item(OP_STATUS + 3'd1, 8'hFF);
        add_item(OP_STATUS + 3'd2, 8'h5A);
        add_item(OP_STATUS + 3'd3, 8'hFF);
        add_item(OP_HOST_WRITE, 8'h5A);
        add_item(OP_STATUS, 8'h00);
        add_item(OP_HOST_READ, 8'h00);
        add_item(OP_HOST_READ, 8'h00);
        wait_drained();

        run_profile(8, 83, 1'b0);
        run_profile(83, 8, 1'b0);
        run_profile(0, 0, 1'b1);

        repeat (DRAIN_WAIT) @(negedge clk);

        $display("Run covered %0d requests under three back-pressure profiles,",
                 n_requests);
        $display("with %0d overruns, %0d empty reads, %0d full writes, %0d bytes sent.",
                 n_overruns, n_empty_rd, n_full_wr, n_sent);
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
